// ===== hdl/rme_pkg.sv =====
// shared constants, types and helpers for the rotation matrix to euler angle block
`default_nettype none
package rme_pkg;

  localparam int unsigned M_W      = 18;   // matrix entry width
  localparam int unsigned ARG_W    = 30;   // atan2 operand width, q.26
  localparam int unsigned SQ_IN_W  = 56;   // radicand width
  localparam int unsigned SQ_OUT_W = 28;   // root width, one stage per bit
  localparam int unsigned ROLL_W   = 19;
  localparam int unsigned PITCH_W  = 18;
  localparam int unsigned YAW_W    = 19;
  localparam int unsigned THR_W    = 10;
  localparam int unsigned OUT_W    = 20;   // common angle width before packing

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] PIH_Q30 = 64'd1686629713;
  localparam logic [19:0] PIH_OUT = 20'd102944;

  localparam logic [63:0] ATAN_Q30 [24] = '{
    64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159,
    64'd67021687,  64'd33543516,  64'd16775851,  64'd8388437,
    64'd4194283,   64'd2097149,   64'd1048576,   64'd524288,
    64'd262144,    64'd131072,    64'd65536,     64'd32768,
    64'd16384,     64'd8192,      64'd4096,      64'd2048,
    64'd1024,      64'd512,       64'd256,       64'd128
  };

  typedef struct packed {
    logic signed [M_W-1:0] m11;
    logic signed [M_W-1:0] m01;
    logic signed [M_W-1:0] m22;
    logic signed [M_W-1:0] m21;
    logic signed [M_W-1:0] m20;
    logic signed [M_W-1:0] m10;
    logic signed [M_W-1:0] m00;
  } mat_t;

  // q30 constant rounded half up to fb fraction bits
  function automatic logic [63:0] q30_round(input logic [63:0] v, input int fb);
    logic [63:0] r;
    if (fb >= 30) begin
      r = v;
    end else begin
      r = (v + (64'd1 << (29 - fb))) >> (30 - fb);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rotation_matrix_to_euler_zyx.sv =====
// zyx euler angles (roll, pitch, yaw) from a rotation matrix, fully pipelined
// One matrix word is taken per clock unless the output stalls, and the angles
// are computed through one squaring stage, a 28-stage bit-per-cycle
// square root for the pitch denominator, four parallel unrolled cordic units of
// CORDIC_STAGES + 2 stages (pitch, yaw, roll and the gimbal-lock roll) and one
// output stage for the lock decision. The whole pipeline holds while a result
// waits at the output. Angles are in radians with 16 fraction bits; the gimbal
// lock window is written on cfg_we_i and resets to one lsb.
`default_nettype none
module rotation_matrix_to_euler_zyx
  import rme_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [THR_W-1:0]  cfg_wdata_i,     // gimbal_threshold
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [127:0]      s_axis_tdata,    // m00, m10, m20, m21, m22, m01, m11, zero pad
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [55:0]            m_axis_tdata,    // roll, pitch, yaw
  output logic                   m_axis_tuser     // gimbal_lock
);

  localparam int unsigned ZW     = FRAC_BITS + 4;
  localparam int unsigned VL     = 1 + SQ_OUT_W + CORDIC_STAGES + 2;
  localparam int unsigned SH_DN  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int unsigned SH_UP  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic signed [39:0] RND =
    (SH_DN == 0) ? 40'sd0 : (40'sd1 <<< ((SH_DN == 0) ? 0 : SH_DN - 1));
  localparam logic signed [ZW-1:0] PIH_F = ZW'(q30_round(PIH_Q30, FRAC_BITS));

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [ZW-1:0] a);
    logic signed [39:0] t;
    t = 40'(a) + RND;
    return OUT_W'((t >>> SH_DN) <<< SH_UP);
  endfunction

  logic ce;
  logic [THR_W-1:0] thr_q;
  logic vld_q [0:VL-1];
  mat_t mat_in;
  mat_t mat_q [0:SQ_OUT_W];
  logic signed [2*M_W-1:0] sq0_q, sq1_q;
  logic [SQ_IN_W-1:0]  radicand;
  logic [SQ_OUT_W-1:0] root;
  logic signed [ZW-1:0] zp, zy, zr, zl;

  logic out_vld_q;
  logic signed [ROLL_W-1:0]  roll_q;
  logic signed [PITCH_W-1:0] pitch_q;
  logic signed [YAW_W-1:0]   yaw_q;
  logic                      lock_q;

  assign ce            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = ce;
  assign mat_in        = mat_t'(s_axis_tdata[7*M_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < VL; k++) vld_q[k] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (ce) begin
      vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < VL; k++) vld_q[k] <= vld_q[k-1];
      out_vld_q <= vld_q[VL-1];
    end
  end

  // squares and matrix delay line alongside the square root
  always_ff @(posedge clk_i) begin
    if (ce) begin
      sq0_q    <= mat_in.m00 * mat_in.m00;
      sq1_q    <= mat_in.m10 * mat_in.m10;
      mat_q[0] <= mat_in;
      for (int k = 1; k <= SQ_OUT_W; k++) mat_q[k] <= mat_q[k-1];
    end
  end

  assign radicand = {36'(sq0_q) + 36'(sq1_q), 20'd0};

  rme_isqrt u_isqrt (
    .clk_i  (clk_i),
    .ce_i   (ce),
    .n_i    (radicand),
    .root_o (root)
  );

  logic signed [ARG_W-1:0] py, px, yy, yx, ry, rx, ly, lx;
  always_comb begin
    py = -(ARG_W'(mat_q[SQ_OUT_W].m20) <<< 10);
    px = ARG_W'(root);
    yy = ARG_W'(mat_q[SQ_OUT_W].m10) <<< 10;
    yx = ARG_W'(mat_q[SQ_OUT_W].m00) <<< 10;
    ry = ARG_W'(mat_q[SQ_OUT_W].m21) <<< 10;
    rx = ARG_W'(mat_q[SQ_OUT_W].m22) <<< 10;
    ly = ARG_W'(mat_q[SQ_OUT_W].m01) <<< 10;
    lx = ARG_W'(mat_q[SQ_OUT_W].m11) <<< 10;
  end

  rme_cordic #(.STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_cordic_pitch (
    .clk_i(clk_i), .ce_i(ce), .y_i(py), .x_i(px), .z_o(zp)
  );
  rme_cordic #(.STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_cordic_yaw (
    .clk_i(clk_i), .ce_i(ce), .y_i(yy), .x_i(yx), .z_o(zy)
  );
  rme_cordic #(.STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_cordic_roll (
    .clk_i(clk_i), .ce_i(ce), .y_i(ry), .x_i(rx), .z_o(zr)
  );
  rme_cordic #(.STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_cordic_lock (
    .clk_i(clk_i), .ce_i(ce), .y_i(ly), .x_i(lx), .z_o(zl)
  );

  // pitch clamp and gimbal lock decision
  logic signed [ZW-1:0]    pc;
  logic signed [OUT_W-1:0] pitch_w, roll_w, yaw_w, lroll_w, apit;
  logic signed [OUT_W:0]   gap;
  logic                    lock;
  always_comb begin
    if (zp > PIH_F) begin
      pc = PIH_F;
    end else if (zp < -PIH_F) begin
      pc = -PIH_F;
    end else begin
      pc = zp;
    end
    pitch_w = to_out(pc);
    roll_w  = to_out(zr);
    yaw_w   = to_out(zy);
    lroll_w = to_out(zl);
    apit    = (pitch_w < 0) ? -pitch_w : pitch_w;
    gap     = (OUT_W + 1)'(apit) - (OUT_W + 1)'(PIH_OUT);
    if (gap < 0) gap = -gap;
    lock = (OUT_W + 1)'(gap) < (OUT_W + 1)'(thr_q);
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      lock_q <= lock;
      if (lock) begin
        yaw_q <= '0;
        if (pitch_w > 0) begin
          pitch_q <= PITCH_W'(PIH_OUT);
          roll_q  <= ROLL_W'(lroll_w);
        end else begin
          pitch_q <= -PITCH_W'(PIH_OUT);
          roll_q  <= ROLL_W'(-lroll_w);
        end
      end else begin
        yaw_q   <= YAW_W'(yaw_w);
        roll_q  <= ROLL_W'(roll_w);
        pitch_q <= PITCH_W'(pitch_w);
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {yaw_q, pitch_q, roll_q};
  assign m_axis_tuser  = lock_q;

endmodule
`default_nettype wire

// ===== hdl/rme_isqrt.sv =====
// pipelined floor integer square root, one root bit per stage
`default_nettype none
module rme_isqrt
  import rme_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                ce_i,
  input  wire logic [SQ_IN_W-1:0]  n_i,
  output logic      [SQ_OUT_W-1:0] root_o
);

  localparam int unsigned AW = SQ_IN_W + 2;

  logic [SQ_IN_W-1:0]  rem_q  [0:SQ_OUT_W];
  logic [SQ_OUT_W-1:0] root_q [0:SQ_OUT_W];

  always_comb begin
    rem_q[0]  = n_i;
    root_q[0] = '0;
  end

  for (genvar k = 0; k < SQ_OUT_W; k++) begin : g_stage
    localparam int unsigned B = SQ_OUT_W - 1 - k;
    logic [AW-1:0] trial;
    logic          take;
    // (2r + 2^b) * 2^b against remainder n - r^2
    assign trial = (AW'(root_q[k]) << (B + 1)) + (AW'(1) << (2 * B));
    assign take  = AW'(rem_q[k]) >= trial;
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[k+1]  <= take ? SQ_IN_W'(AW'(rem_q[k]) - trial) : rem_q[k];
        root_q[k+1] <= take ? (root_q[k] | (SQ_OUT_W'(1) << B)) : root_q[k];
      end
    end
  end

  assign root_o = root_q[SQ_OUT_W];

endmodule
`default_nettype wire

// ===== hdl/rme_cordic.sv =====
// pipelined vectoring cordic atan2 with quadrant fold, saturation to +-pi and zero for a zero vector
`default_nettype none
module rme_cordic
  import rme_pkg::*;
#(
  parameter int unsigned STAGES    = 16,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned ZW       = FRAC_BITS + 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    ce_i,
  input  wire logic signed [ARG_W-1:0] y_i,
  input  wire logic signed [ARG_W-1:0] x_i,
  output logic signed [ZW-1:0]         z_o
);

  localparam int unsigned W = ARG_W + 22;
  localparam logic signed [ZW-1:0] PI_F = ZW'(q30_round(PI_Q30, FRAC_BITS));

  logic signed [W-1:0]  x_q [0:STAGES];
  logic signed [W-1:0]  y_q [0:STAGES];
  logic signed [ZW-1:0] z_q [0:STAGES];
  logic                 zero_q [0:STAGES];
  logic signed [ZW-1:0] z_out_q;

  logic                    neg;
  logic signed [ARG_W-1:0] xf, yf;
  logic signed [ZW-1:0]    z0;

  always_comb begin
    neg = x_i < 0;
    xf  = neg ? -x_i : x_i;
    yf  = neg ? -y_i : y_i;
    z0  = neg ? ((y_i >= 0) ? PI_F : -PI_F) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      x_q[0]    <= W'(xf) <<< 20;
      y_q[0]    <= W'(yf) <<< 20;
      z_q[0]    <= z0;
      zero_q[0] <= (x_i == 0) && (y_i == 0);
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] A = ZW'(q30_round(ATAN_Q30[i], FRAC_BITS));
    logic signed [W-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + A;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - A;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      if (zero_q[STAGES]) begin
        z_out_q <= '0;
      end else if (z_q[STAGES] > PI_F) begin
        z_out_q <= PI_F;
      end else if (z_q[STAGES] < -PI_F) begin
        z_out_q <= -PI_F;
      end else begin
        z_out_q <= z_q[STAGES];
      end
    end
  end

  assign z_o = z_out_q;

endmodule
`default_nettype wire

// ===== bench/rotation_matrix_to_euler_zyx_tb.sv =====
// testbench for the rotation matrix to zyx euler angle block
`timescale 1ns / 1ps
`default_nettype none

class euler_scoreboard;
  logic [55:0] angle_q[$];
  bit          lock_q[$];
  int          n_bad;
  int          n_words_out;
  int          n_locked;
  logic [9:0]  lock_window;

  function new();
    n_bad = 0;
    n_words_out = 0;
    n_locked = 0;
    lock_window = 10'd1;
  endfunction

  // arithmetic shift right on 64-bit signed
  static function longint sra(longint v, int s);
    return v >>> s;
  endfunction

  // cordic atan2 in q.16 angle, operands q.26
  static function longint atan2_q16(longint y, longint x);
    longint z, xs, ys, a, pi;
    pi = longint'(rme_pkg::q30_round(rme_pkg::PI_Q30, 16));
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? pi : -pi;
      x = -x;
      y = -y;
    end
    x = x * (64'sd1 <<< 20);
    y = y * (64'sd1 <<< 20);
    for (int i = 0; i < 16; i++) begin
      xs = sra(x, i);
      ys = sra(y, i);
      a = longint'(rme_pkg::q30_round(rme_pkg::ATAN_Q30[i], 16));
      if (y >= 0) begin
        x += ys; y -= xs; z += a;
      end else begin
        x -= ys; y += xs; z -= a;
      end
    end
    if (z > pi) z = pi;
    if (z < -pi) z = -pi;
    return z;
  endfunction

  static function longint int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return longint'(root);
  endfunction

  function void note_matrix(rme_pkg::mat_t m);
    longint m00, m10, m20, m21, m22, m01, m11, pih, pih_out, root, p, pitch, roll, yaw, gap;
    longint unsigned sumsq;
    bit lock;
    m00 = m.m00; m10 = m.m10; m20 = m.m20; m21 = m.m21;
    m22 = m.m22; m01 = m.m01; m11 = m.m11;
    pih = longint'(rme_pkg::q30_round(rme_pkg::PIH_Q30, 16));
    pih_out = 102944;
    sumsq = longint'(m00 * m00 + m10 * m10) << 20;
    root = int_sqrt(sumsq);
    p = atan2_q16(-m20 * 1024, root);
    if (p > pih) p = pih;
    if (p < -pih) p = -pih;
    pitch = p;
    gap = (pitch < 0 ? -pitch : pitch) - pih_out;
    if (gap < 0) gap = -gap;
    lock = gap < longint'(lock_window);
    if (lock) begin
      yaw = 0;
      roll = atan2_q16(m01 * 1024, m11 * 1024);
      if (pitch > 0) begin
        pitch = pih_out;
      end else begin
        pitch = -pih_out;
        roll = -roll;
      end
    end else begin
      yaw = atan2_q16(m10 * 1024, m00 * 1024);
      roll = atan2_q16(m21 * 1024, m22 * 1024);
    end
    angle_q.push_back({yaw[18:0], pitch[17:0], roll[18:0]});
    lock_q.push_back(lock);
  endfunction

  function void check_angles(logic [55:0] got, logic got_lock, time t);
    logic [55:0] want;
    bit want_lock;
    n_words_out++;
    if (got_lock === 1'b1) n_locked++;
    if (angle_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %h/%b", t, got, got_lock);
      n_bad++;
      return;
    end
    want = angle_q.pop_front();
    want_lock = lock_q.pop_front();
    if (got[18:0] !== want[18:0]) begin
      $display("%0t: roll expected %h actual %h", t, want[18:0], got[18:0]);
      n_bad++;
    end
    if (got[36:19] !== want[36:19]) begin
      $display("%0t: pitch expected %h actual %h", t, want[36:19], got[36:19]);
      n_bad++;
    end
    if (got[55:37] !== want[55:37]) begin
      $display("%0t: yaw expected %h actual %h", t, want[55:37], got[55:37]);
      n_bad++;
    end
    if (got_lock !== want_lock) begin
      $display("%0t: gimbal_lock expected %b actual %b", t, want_lock, got_lock);
      n_bad++;
    end
  endfunction
endclass

module rotation_matrix_to_euler_zyx_tb;
  import rme_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 80;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [9:0]    cfg_wdata_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [127:0]  s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [55:0]   m_axis_tdata;
  logic          m_axis_tuser;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  idle_cycles = 0;
  int  n_words_in = 0;
  bit  timed_out = 0;
  euler_scoreboard angle_board;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rotation_matrix_to_euler_zyx uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // receiver side stalls and result checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        angle_board.check_angles(m_axis_tdata, m_axis_tuser, $time);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [17:0] rand_entry();
    int k;
    k = $urandom_range(9);
    case (k)
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'd0;
      3: return 18'(($urandom & 32'h3ffff));
      default: return 18'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // random matrices, one in four a near gimbal lock row: m20 at exactly +-1, m00 and m10 small
  function automatic mat_t rand_matrix();
    mat_t m;
    m.m00 = rand_entry(); m.m10 = rand_entry(); m.m20 = rand_entry();
    m.m21 = rand_entry(); m.m22 = rand_entry(); m.m01 = rand_entry();
    m.m11 = rand_entry();
    if ($urandom_range(3) == 0) begin
      m.m20 = $urandom_range(1) ? 18'sd65536 : -18'sd65536;
      m.m00 = 18'($signed($urandom_range(64)) - 32);
      m.m10 = 18'($signed($urandom_range(64)) - 32);
    end
    return m;
  endfunction

  // tvalid stays high between back to back words and drops only while idling
  task automatic send_matrix(input mat_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b0, m};
    angle_board.note_matrix(m);
    n_words_in++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [9:0] v);
    s_axis_tvalid <= 1'b0;
    while (angle_board.angle_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    angle_board.lock_window = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic mat_t mk(int a, int b, int c, int d, int e, int f, int g);
    mat_t m;
    m.m00 = 18'(a); m.m10 = 18'(b); m.m20 = 18'(c); m.m21 = 18'(d);
    m.m22 = 18'(e); m.m01 = 18'(f); m.m11 = 18'(g);
    return m;
  endfunction

  task automatic random_phase(input int n, input int sp, input int rp);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    repeat (n) send_matrix(rand_matrix());
  endtask

  initial begin
    angle_board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, all-zero, negative x, lock both signs, out of range
    send_matrix(mk(65536, 0, 0, 0, 65536, 0, 65536));
    send_matrix(mk(0, 0, 0, 0, 0, 0, 0));
    send_matrix(mk(-65536, 0, 0, 0, -65536, 0, -65536));
    send_matrix(mk(-65536, -1, 0, -1, -65536, 0, 65536));
    send_matrix(mk(0, 0, -65536, 46341, 46341, 46341, 46341));
    send_matrix(mk(0, 0, 65536, 46341, 46341, -46341, 46341));
    send_matrix(mk(3, -2, 65536, 0, 0, 0, 0));
    send_matrix(mk(131071, -131072, 131071, -131072, 131071, -131072, 131071));
    send_matrix(mk(-131072, 131071, -131072, 131071, -131072, 131071, -131072));
    send_matrix(mk(-1, -1, -1, -1, -1, -1, -1));
    send_matrix(mk(46341, 46341, 0, 65536, 0, 0, 65536));
    send_matrix(mk(0, 65536, 0, -65536, 0, -65536, 0));

    write_window(10'd0);
    send_matrix(mk(0, 0, -65536, 0, 0, 65536, 0));
    send_matrix(mk(0, 0, 65536, 0, 0, 65536, 0));
    random_phase(200, 27, 78);
    write_window(10'd1023);
    send_matrix(mk(65536, 0, 0, 0, 65536, 0, 65536));
    send_matrix(mk(-65536, 0, 0, 0, 65536, 0, 65536));
    random_phase(400, 27, 78);
    write_window(10'd40);
    random_phase(400, 78, 27);
    write_window(10'd1);
    random_phase(430, 0, 0);
    s_axis_tvalid <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;

    while (angle_board.angle_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("sent %0d matrices, checked %0d angle words, %0d in gimbal lock",
             n_words_in, angle_board.n_words_out, angle_board.n_locked);
    $display("lock windows 0, 1, 40 and 1023 used under varied stalls");
    if (angle_board.n_bad == 0 && angle_board.angle_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

`default_nettype wire
